// File: rtl/core/pidsep_pkg.sv
package pidsep_pkg;

  localparam int unsigned GAIN_FRAC_BITS = 8;
  localparam int unsigned POS_WIDTH      = 16;

  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned SEP_W    = 16;
  localparam int unsigned BOUND_W  = 16;
  localparam int unsigned LIMIT_W  = 15;
  localparam int unsigned DRIVE_W  = 16;
  localparam int unsigned SUM_W    = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // error, its magnitude and the derivative difference
  localparam int unsigned ERR_W  = POS_WIDTH + 1;
  localparam int unsigned DERR_W = POS_WIDTH + 2;
  localparam int unsigned CMP_W  = (ERR_W > SEP_W) ? ERR_W : SEP_W;
  localparam int unsigned SUMX_W = ((ERR_W > SUM_W) ? ERR_W : SUM_W) + 1;

  // products of a zero-extended unsigned gain with signed operands
  localparam int unsigned PP_W  = GAIN_W + 1 + ERR_W;
  localparam int unsigned PD_W  = GAIN_W + 1 + DERR_W;
  localparam int unsigned PI_W  = GAIN_W + 1 + SUM_W;
  localparam int unsigned ACC_W = ((PD_W > PI_W) ? PD_W : PI_W) + 2;

  localparam int unsigned ROUND_ADD = (1 << GAIN_FRAC_BITS) - 1;

  // input register, integral stage, product stage, sum stage, output register
  localparam int unsigned PIPE_DEPTH = 5;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  localparam logic [GAIN_W-1:0]         GAIN_P_RST    = GAIN_W'(768);
  localparam logic [GAIN_W-1:0]         GAIN_I_RST    = GAIN_W'(0);
  localparam logic [GAIN_W-1:0]         GAIN_D_RST    = GAIN_W'(307);
  localparam logic signed [BOUND_W-1:0] SUM_UPPER_RST = BOUND_W'(200);
  localparam logic signed [BOUND_W-1:0] SUM_LOWER_RST = -BOUND_W'(200);
  localparam logic [LIMIT_W-1:0]        OUT_LIMIT_RST = LIMIT_W'(70);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P    = 3'd0,
    CFG_GAIN_I    = 3'd1,
    CFG_GAIN_D    = 3'd2,
    CFG_SUM_UPPER = 3'd3,
    CFG_SUM_LOWER = 3'd4,
    CFG_OUT_LIMIT = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic signed [ERR_W-1:0]  err;
    logic signed [DERR_W-1:0] derr;
    logic                     on;
    logic signed [SUM_W-1:0]  sum;   // zero when the integral path is off
  } integ_t;

endpackage

// File: rtl/core/pidsep_if.sv
interface pidsep_in_if;
  logic                                        valid;
  logic                                        ready;
  logic signed [pidsep_pkg::POS_WIDTH-1:0]     target;
  logic signed [pidsep_pkg::POS_WIDTH-1:0]     measured;
  logic        [pidsep_pkg::SEP_W-1:0]         separation_limit;

  modport source (output valid, target, measured, separation_limit, input ready);
  modport sink   (input valid, target, measured, separation_limit, output ready);
endinterface

interface pidsep_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [pidsep_pkg::DRIVE_W-1:0]   drive;
  logic                                    integral_on;

  modport source (output valid, drive, integral_on, input ready);
  modport sink   (input valid, drive, integral_on, output ready);
endinterface

interface pidsep_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [pidsep_pkg::CFG_IDX_W-1:0]      index;
  logic [pidsep_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/pid_integral_separation_antiwindup.sv
// Positional PID step with integral separation and anti-windup. Each accepted
// word (target, measured, separation_limit) yields one drive word, in order.
// The block takes one word per clock while the output is not stalled; the
// five register stages are input, integral update, the three gain products,
// their sum, and the truncated and clamped output. The error-sum register's
// compare, add and saturate logic is combinational, ahead of that register.
// Configuration writes are always ready and must only be issued while the
// pipeline is empty.
module pid_integral_separation_antiwindup (
  input  logic         clk_i,
  input  logic         rst_ni,
  pidsep_in_if.sink    in_i,
  pidsep_out_if.source out_o,
  pidsep_cfg_if.sink   cfg_i
);

  // configuration registers
  logic        [pidsep_pkg::GAIN_W-1:0]  gain_p_q, gain_i_q, gain_d_q;
  logic signed [pidsep_pkg::BOUND_W-1:0] sum_upper_q, sum_lower_q;
  logic        [pidsep_pkg::LIMIT_W-1:0] out_limit_q;

  // stage valids and enables
  logic v0_q, v1_q, v2_q, v3_q, v4_q;
  logic en0, en1, en2, en3, en4;

  // stage payloads
  logic signed [pidsep_pkg::POS_WIDTH-1:0] tgt0_q, meas0_q;
  logic        [pidsep_pkg::SEP_W-1:0]     sep0_q;
  pidsep_pkg::integ_t                      integ;
  pidsep_pkg::integ_t                      s1_q;
  logic signed [pidsep_pkg::PP_W-1:0]      pp_d, pp_q;
  logic signed [pidsep_pkg::PD_W-1:0]      pd_d, pd_q;
  logic signed [pidsep_pkg::PI_W-1:0]      pi_d, pi_q;
  logic                                    on2_q, on3_q, on4_q;
  logic signed [pidsep_pkg::ACC_W-1:0]     acc_d, acc_q;
  logic signed [pidsep_pkg::DRIVE_W-1:0]   drive_d, drive_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q    <= pidsep_pkg::GAIN_P_RST;
      gain_i_q    <= pidsep_pkg::GAIN_I_RST;
      gain_d_q    <= pidsep_pkg::GAIN_D_RST;
      sum_upper_q <= pidsep_pkg::SUM_UPPER_RST;
      sum_lower_q <= pidsep_pkg::SUM_LOWER_RST;
      out_limit_q <= pidsep_pkg::OUT_LIMIT_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        pidsep_pkg::CFG_GAIN_P:    gain_p_q    <= cfg_i.data;
        pidsep_pkg::CFG_GAIN_I:    gain_i_q    <= cfg_i.data;
        pidsep_pkg::CFG_GAIN_D:    gain_d_q    <= cfg_i.data;
        pidsep_pkg::CFG_SUM_UPPER: sum_upper_q <= cfg_i.data;
        pidsep_pkg::CFG_SUM_LOWER: sum_lower_q <= cfg_i.data;
        pidsep_pkg::CFG_OUT_LIMIT: out_limit_q <= cfg_i.data[pidsep_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // a stage loads when it is empty or its word moves on
  assign en4 = !v4_q || out_o.ready;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign en0 = !v0_q || en1;

  assign in_i.ready = en0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en0) v0_q <= in_i.valid;
      if (en1) v1_q <= v0_q;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  pidsep_integ u_integ (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (v0_q && en1),
    .target_i    (tgt0_q),
    .measured_i  (meas0_q),
    .sep_i       (sep0_q),
    .sum_upper_i (sum_upper_q),
    .sum_lower_i (sum_lower_q),
    .integ_o     (integ)
  );

  assign pp_d = $signed({1'b0, gain_p_q}) * s1_q.err;
  assign pd_d = $signed({1'b0, gain_d_q}) * s1_q.derr;
  assign pi_d = $signed({1'b0, gain_i_q}) * s1_q.sum;

  assign acc_d = pidsep_pkg::ACC_W'(pp_q) + pidsep_pkg::ACC_W'(pd_q)
               + pidsep_pkg::ACC_W'(pi_q);

  pidsep_drive u_drive (
    .acc_i       (acc_q),
    .out_limit_i (out_limit_q),
    .drive_o     (drive_d)
  );

  always_ff @(posedge clk_i) begin
    if (en0 && in_i.valid) begin
      tgt0_q  <= in_i.target;
      meas0_q <= in_i.measured;
      sep0_q  <= in_i.separation_limit;
    end
    if (en1 && v0_q) begin
      s1_q <= integ;
    end
    if (en2 && v1_q) begin
      pp_q  <= pp_d;
      pd_q  <= pd_d;
      pi_q  <= pi_d;
      on2_q <= s1_q.on;
    end
    if (en3 && v2_q) begin
      acc_q <= acc_d;
      on3_q <= on2_q;
    end
    if (en4 && v3_q) begin
      drive_q <= drive_d;
      on4_q   <= on3_q;
    end
  end

  assign out_o.valid       = v4_q;
  assign out_o.drive       = drive_q;
  assign out_o.integral_on = on4_q;

endmodule

// File: rtl/core/pidsep_integ.sv
module pidsep_integ (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    advance_i,
  input  logic signed [pidsep_pkg::POS_WIDTH-1:0] target_i,
  input  logic signed [pidsep_pkg::POS_WIDTH-1:0] measured_i,
  input  logic        [pidsep_pkg::SEP_W-1:0]     sep_i,
  input  logic signed [pidsep_pkg::BOUND_W-1:0]   sum_upper_i,
  input  logic signed [pidsep_pkg::BOUND_W-1:0]   sum_lower_i,
  output pidsep_pkg::integ_t                      integ_o
);

  logic signed [pidsep_pkg::SUM_W-1:0]  error_sum_q, error_sum_d;
  logic signed [pidsep_pkg::ERR_W-1:0]  prev_err_q;
  logic signed [pidsep_pkg::ERR_W-1:0]  err;
  logic        [pidsep_pkg::ERR_W-1:0]  mag;
  logic                                 on;
  logic                                 add;
  logic signed [pidsep_pkg::SUM_W-1:0]  upper_x, lower_x;
  logic signed [pidsep_pkg::SUMX_W-1:0] sum_x;

  assign err = pidsep_pkg::ERR_W'(target_i) - pidsep_pkg::ERR_W'(measured_i);
  // most negative error wraps to itself, which reads correctly as unsigned
  assign mag = err[pidsep_pkg::ERR_W-1] ? pidsep_pkg::ERR_W'(-err) : pidsep_pkg::ERR_W'(err);
  assign on  = pidsep_pkg::CMP_W'(mag) < pidsep_pkg::CMP_W'(sep_i);

  assign upper_x = pidsep_pkg::SUM_W'(sum_upper_i);
  assign lower_x = pidsep_pkg::SUM_W'(sum_lower_i);
  assign sum_x   = pidsep_pkg::SUMX_W'(error_sum_q) + pidsep_pkg::SUMX_W'(err);

  always_comb begin
    // upper bound is tested first, so it wins when the bounds cross
    if (error_sum_q >= upper_x) begin
      add = (err <= 0);
    end else if (error_sum_q <= lower_x) begin
      add = (err >= 0);
    end else begin
      add = 1'b1;
    end

    error_sum_d = error_sum_q;
    if (on && add) begin
      if (sum_x > pidsep_pkg::SUMX_W'(pidsep_pkg::SUM_MAX)) begin
        error_sum_d = pidsep_pkg::SUM_MAX;
      end else if (sum_x < pidsep_pkg::SUMX_W'(pidsep_pkg::SUM_MIN)) begin
        error_sum_d = pidsep_pkg::SUM_MIN;
      end else begin
        error_sum_d = sum_x[pidsep_pkg::SUM_W-1:0];
      end
    end
  end

  always_comb begin
    integ_o.err  = err;
    integ_o.derr = pidsep_pkg::DERR_W'(err) - pidsep_pkg::DERR_W'(prev_err_q);
    integ_o.on   = on;
    integ_o.sum  = on ? error_sum_d : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      error_sum_q <= '0;
      prev_err_q  <= '0;
    end else if (advance_i) begin
      error_sum_q <= error_sum_d;
      prev_err_q  <= err;
    end
  end

endmodule

// File: rtl/core/pidsep_drive.sv
module pidsep_drive (
  input  logic signed [pidsep_pkg::ACC_W-1:0]   acc_i,
  input  logic        [pidsep_pkg::LIMIT_W-1:0] out_limit_i,
  output logic signed [pidsep_pkg::DRIVE_W-1:0] drive_o
);

  logic signed [pidsep_pkg::ACC_W-1:0] adj;
  logic signed [pidsep_pkg::ACC_W-1:0] quo;
  logic signed [pidsep_pkg::ACC_W-1:0] lim;

  // bias negatives so the arithmetic shift truncates toward zero
  assign adj = acc_i + (acc_i[pidsep_pkg::ACC_W-1] ?
                        pidsep_pkg::ACC_W'(pidsep_pkg::ROUND_ADD) : '0);
  assign quo = adj >>> pidsep_pkg::GAIN_FRAC_BITS;
  assign lim = pidsep_pkg::ACC_W'({1'b0, out_limit_i});

  always_comb begin
    if (quo > lim) begin
      drive_o = lim[pidsep_pkg::DRIVE_W-1:0];
    end else if (quo < -lim) begin
      drive_o = pidsep_pkg::DRIVE_W'(-lim);
    end else begin
      drive_o = quo[pidsep_pkg::DRIVE_W-1:0];
    end
  end

endmodule

// File: rtl/core/pidsep_checker.sv
module pidsep_checker (
  input logic                                    clk_i,
  input logic                                    rst_ni,
  input logic                                    in_valid_i,
  input logic                                    in_ready_i,
  input logic                                    out_valid_i,
  input logic                                    out_ready_i,
  input logic signed [pidsep_pkg::DRIVE_W-1:0]   out_drive_i,
  input logic                                    out_on_i,
  input logic                                    cfg_valid_i,
  input logic                                    cfg_ready_i,
  input logic [pidsep_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input logic [pidsep_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  logic [2:0]                         cnt_q;
  logic [pidsep_pkg::LIMIT_W-1:0]     lim_q;
  logic                               in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // words in flight and mirrored drive clamp
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      lim_q <= pidsep_pkg::OUT_LIMIT_RST;
    end else begin
      cnt_q <= cnt_q + 3'(in_acc) - 3'(out_acc);
      if (cfg_valid_i && cfg_ready_i && cfg_index_i == pidsep_pkg::CFG_OUT_LIMIT) begin
        lim_q <= cfg_data_i[pidsep_pkg::LIMIT_W-1:0];
      end
    end
  end

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> cnt_q != 3'd0)
    else $error("result word without an outstanding input word");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'(pidsep_pkg::PIPE_DEPTH))
    else $error("more words in flight than pipeline stages");

  a_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ($signed(out_drive_i) <= $signed({1'b0, lim_q}) &&
                     $signed(out_drive_i) >= -$signed({1'b0, lim_q})))
    else $error("drive outside the configured clamp");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_drive_i) && $stable(out_on_i))
    else $error("stalled result word changed");

endmodule

bind pid_integral_separation_antiwindup pidsep_checker u_pidsep_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_drive_i (out_o.drive),
  .out_on_i    (out_o.integral_on),
  .cfg_valid_i (cfg_i.valid),
  .cfg_ready_i (cfg_i.ready),
  .cfg_index_i (cfg_i.index),
  .cfg_data_i  (cfg_i.data)
);
